// File: rtl/sfr_pkg.sv
// Shared types and fixed-point constants for the Schlick reflectance pipeline.
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

    localparam int VEC_FRAC_BITS = 14;
    localparam int WF            = 30;
    localparam int SH            = 2 * VEC_FRAC_BITS - WF;
    localparam int SHL           = (SH < 0) ? -SH : 0;
    localparam int SHR           = (SH > 0) ? SH : 0;
    localparam int DOTW          = 34;
    localparam int MAGW          = DOTW + SHL;
    localparam int DIV_STEPS     = 34;
    localparam int SQRT_STEPS    = 31;
    localparam int POW_STEPS     = 4;

    localparam logic [13:0] INDEX_ONE = 14'd4096;
    localparam logic [30:0] ONE_W     = 31'h4000_0000;
    localparam logic [61:0] ONE_SQ    = 62'd1 << 60;
    localparam logic [15:0] REFL_ONE  = 16'h8000;

    typedef struct packed {
        logic signed [15:0] eye_x;
        logic signed [15:0] eye_y;
        logic signed [15:0] eye_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [13:0]        index_from;
        logic [13:0]        index_to;
    } t_hit;

    typedef struct packed {
        logic [15:0] reflectance;
        logic        total_internal;
    } t_refl;

endpackage
`default_nettype wire

// File: rtl/schlick_fresnel_reflectance.sv
// Schlick Fresnel reflectance: pipelined top level.
//
// Input channel i_in_valid / o_in_ready / i_in_data carries one hit per
// transaction: eye vector, surface normal and the two refractive indices.
// Output channel o_out_valid / i_out_ready / o_out_data returns one result
// per hit, in order: reflectance in Q1.15 and the total internal flag.
// The pipeline has 79 register stages; throughput is one transaction per
// cycle while the output register is not held. The length is set by two
// bit-per-stage dividers (34 stages, the sin^2 and r0 quotients side by
// side) and a bit-per-stage square root (31 stages), plus the multiply
// stages of the dot product and the fifth power.
// Reset clears every stage valid bit; the pipeline comes up empty and
// ready. When the receiver holds i_out_ready low with a result waiting,
// the whole pipeline holds; o_in_ready falls and nothing is lost or
// repeated. While the output register is empty or being taken, a new
// transaction enters every cycle.
`timescale 1ns / 1ps
`default_nettype none
module schlick_fresnel_reflectance (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sfr_pkg::t_hit  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sfr_pkg::t_refl o_out_data
);
    import sfr_pkg::*;

    logic en;

    // stage 1
    logic               r_v1;
    logic signed [31:0] r_px, r_py, r_pz;
    logic [13:0]        r_n1_1, r_n2_1;
    // stage 2
    logic               r_v2;
    logic signed [33:0] r_dot;
    logic [13:0]        r_n1_2, r_n2_2;
    // stage 3
    logic               r_v3;
    logic [30:0]        r_mag3;
    logic               r_cneg3, r_gt3;
    logic [13:0]        r_n1_3, r_n2_3, r_d3;
    logic [14:0]        r_s3;
    // stage 4
    logic               r_v4;
    logic [61:0]        r_mag2;
    logic [27:0]        r_n1sq4, r_n2sq4, r_dsq4;
    logic [29:0]        r_ssq4;
    logic [30:0]        r_mag4;
    logic               r_cneg4, r_gt4;
    // stage 5
    logic               r_v5;
    logic [30:0]        r_sval;
    logic [27:0]        r_n1sq5, r_n2sq5, r_dsq5;
    logic [29:0]        r_ssq5;
    logic [30:0]        r_mag5;
    logic               r_cneg5, r_gt5;

    // divider lanes
    logic [DIV_STEPS:0] r_dv_v;
    logic [57:0]        r_dv_ra [DIV_STEPS+1];
    logic [57:0]        r_dv_rb [DIV_STEPS+1];
    logic [33:0]        r_dv_qa [DIV_STEPS+1];
    logic [33:0]        r_dv_qb [DIV_STEPS+1];
    logic [27:0]        r_dv_da [DIV_STEPS+1];
    logic [29:0]        r_dv_db [DIV_STEPS+1];
    logic [30:0]        r_dv_mag [DIV_STEPS+1];
    logic               r_dv_cneg [DIV_STEPS+1];
    logic               r_dv_gt [DIV_STEPS+1];

    // square root lanes
    logic [SQRT_STEPS:0] r_sq_v;
    logic [61:0]         r_sq_x [SQRT_STEPS+1];
    logic [32:0]         r_sq_rem [SQRT_STEPS+1];
    logic [30:0]         r_sq_res [SQRT_STEPS+1];
    logic [30:0]         r_sq_r0 [SQRT_STEPS+1];
    logic [30:0]         r_sq_mag [SQRT_STEPS+1];
    logic                r_sq_cneg [SQRT_STEPS+1];
    logic                r_sq_gt [SQRT_STEPS+1];
    logic                r_sq_tir [SQRT_STEPS+1];

    // fifth power lanes
    logic [POW_STEPS:0] r_mp_v;
    logic [30:0]        r_mp [POW_STEPS+1];
    logic [30:0]        r_mm [POW_STEPS+1];
    logic [30:0]        r_mr0 [POW_STEPS+1];
    logic               r_mtir [POW_STEPS+1];
    logic               r_mback [POW_STEPS+1];

    // blend stage
    logic               r_vt;
    logic [30:0]        r_t, r_t_r0;
    logic               r_t_tir, r_t_back;

    // output register
    logic               r_out_valid;
    t_refl              r_out_data;

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    logic [13:0] n1_in, n2_in;
    assign n1_in = (i_in_data.index_from < INDEX_ONE) ? INDEX_ONE : i_in_data.index_from;
    assign n2_in = (i_in_data.index_to < INDEX_ONE) ? INDEX_ONE : i_in_data.index_to;

    logic [33:0]     dabs;
    logic [MAGW-1:0] mag_sh;
    logic [30:0]     mag_c;
    assign dabs   = r_dot[33] ? $unsigned(-r_dot) : $unsigned(r_dot);
    assign mag_sh = (MAGW'(dabs) << SHL) >> SHR;
    assign mag_c  = (mag_sh > MAGW'(ONE_W)) ? ONE_W : mag_sh[30:0];

    logic [61:0] sdiff;
    logic [58:0] num;
    assign sdiff = ONE_SQ - r_mag2;
    assign num   = 59'(r_n1sq5) * 59'(r_sval);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_dv_v <= '0;
            r_sq_v <= '0;
            r_mp_v <= '0;
        end else if (en) begin
            r_v1   <= i_in_valid;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v5   <= r_v4;
            r_dv_v <= {r_dv_v[DIV_STEPS-1:0], r_v5};
            r_sq_v <= {r_sq_v[SQRT_STEPS-1:0], r_dv_v[DIV_STEPS]};
            r_mp_v <= {r_mp_v[POW_STEPS-1:0], r_sq_v[SQRT_STEPS]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px   <= i_in_data.eye_x * i_in_data.normal_x;
            r_py   <= i_in_data.eye_y * i_in_data.normal_y;
            r_pz   <= i_in_data.eye_z * i_in_data.normal_z;
            r_n1_1 <= n1_in;
            r_n2_1 <= n2_in;

            r_dot  <= 34'(r_px) + 34'(r_py) + 34'(r_pz);
            r_n1_2 <= r_n1_1;
            r_n2_2 <= r_n2_1;

            r_mag3  <= mag_c;
            r_cneg3 <= r_dot[33] && (mag_c != '0);
            r_gt3   <= r_n1_2 > r_n2_2;
            r_n1_3  <= r_n1_2;
            r_n2_3  <= r_n2_2;
            r_d3    <= (r_n1_2 > r_n2_2) ? (r_n1_2 - r_n2_2) : (r_n2_2 - r_n1_2);
            r_s3    <= 15'(r_n1_2) + 15'(r_n2_2);

            r_mag2  <= 62'(r_mag3) * 62'(r_mag3);
            r_n1sq4 <= 28'(r_n1_3) * 28'(r_n1_3);
            r_n2sq4 <= 28'(r_n2_3) * 28'(r_n2_3);
            r_dsq4  <= 28'(r_d3) * 28'(r_d3);
            r_ssq4  <= 30'(r_s3) * 30'(r_s3);
            r_mag4  <= r_mag3;
            r_cneg4 <= r_cneg3;
            r_gt4   <= r_gt3;

            r_sval  <= sdiff[60:30];
            r_n1sq5 <= r_n1sq4;
            r_n2sq5 <= r_n2sq4;
            r_dsq5  <= r_dsq4;
            r_ssq5  <= r_ssq4;
            r_mag5  <= r_mag4;
            r_cneg5 <= r_cneg4;
            r_gt5   <= r_gt4;

            r_dv_ra[0]   <= num[57:0];
            r_dv_rb[0]   <= {r_dsq5, 30'b0};
            r_dv_qa[0]   <= '0;
            r_dv_qb[0]   <= '0;
            r_dv_da[0]   <= r_n2sq5;
            r_dv_db[0]   <= r_ssq5;
            r_dv_mag[0]  <= r_mag5;
            r_dv_cneg[0] <= r_cneg5;
            r_dv_gt[0]   <= r_gt5;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= DIV_STEPS; k++) begin : g_div
            localparam int          B    = DIV_STEPS - k;
            localparam logic [33:0] QBIT = 34'd1 << B;
            logic [63:0] dena, denb;
            logic        ta, tb;
            assign dena = 64'(r_dv_da[k-1]) << B;
            assign denb = 64'(r_dv_db[k-1]) << B;
            assign ta   = {6'b0, r_dv_ra[k-1]} >= dena;
            assign tb   = {6'b0, r_dv_rb[k-1]} >= denb;

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_ra[k]   <= ta ? (r_dv_ra[k-1] - dena[57:0]) : r_dv_ra[k-1];
                    r_dv_rb[k]   <= tb ? (r_dv_rb[k-1] - denb[57:0]) : r_dv_rb[k-1];
                    r_dv_qa[k]   <= ta ? (r_dv_qa[k-1] | QBIT) : r_dv_qa[k-1];
                    r_dv_qb[k]   <= tb ? (r_dv_qb[k-1] | QBIT) : r_dv_qb[k-1];
                    r_dv_da[k]   <= r_dv_da[k-1];
                    r_dv_db[k]   <= r_dv_db[k-1];
                    r_dv_mag[k]  <= r_dv_mag[k-1];
                    r_dv_cneg[k] <= r_dv_cneg[k-1];
                    r_dv_gt[k]   <= r_dv_gt[k-1];
                end
            end
        end
    endgenerate

    logic [33:0] sin2;
    logic        tir;
    logic [61:0] rad;
    assign sin2 = r_dv_qa[DIV_STEPS];
    assign tir  = r_dv_gt[DIV_STEPS] && (sin2 > 34'(ONE_W));
    assign rad  = (r_dv_gt[DIV_STEPS] && !tir) ? (62'(ONE_W - sin2[30:0]) << WF) : '0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_x[0]    <= rad;
            r_sq_rem[0]  <= '0;
            r_sq_res[0]  <= '0;
            r_sq_r0[0]   <= r_dv_qb[DIV_STEPS][30:0];
            r_sq_mag[0]  <= r_dv_mag[DIV_STEPS];
            r_sq_cneg[0] <= r_dv_cneg[DIV_STEPS];
            r_sq_gt[0]   <= r_dv_gt[DIV_STEPS];
            r_sq_tir[0]  <= tir;
        end
    end

    generate
        for (k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
            logic [34:0] remsh, trial;
            logic        ge;
            assign remsh = {r_sq_rem[k-1], r_sq_x[k-1][61:60]};
            assign trial = {2'b0, r_sq_res[k-1], 2'b01};
            assign ge    = remsh >= trial;

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_x[k]    <= {r_sq_x[k-1][59:0], 2'b00};
                    r_sq_rem[k]  <= ge ? 33'(remsh - trial) : remsh[32:0];
                    r_sq_res[k]  <= {r_sq_res[k-1][29:0], ge};
                    r_sq_r0[k]   <= r_sq_r0[k-1];
                    r_sq_mag[k]  <= r_sq_mag[k-1];
                    r_sq_cneg[k] <= r_sq_cneg[k-1];
                    r_sq_gt[k]   <= r_sq_gt[k-1];
                    r_sq_tir[k]  <= r_sq_tir[k-1];
                end
            end
        end
    endgenerate

    logic [30:0] cosm, m0;
    assign cosm = r_sq_gt[SQRT_STEPS] ? r_sq_res[SQRT_STEPS] : r_sq_mag[SQRT_STEPS];
    assign m0   = ONE_W - cosm;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mp[0]    <= m0;
            r_mm[0]    <= m0;
            r_mr0[0]   <= r_sq_r0[SQRT_STEPS];
            r_mtir[0]  <= r_sq_tir[SQRT_STEPS];
            r_mback[0] <= !r_sq_gt[SQRT_STEPS] && r_sq_cneg[SQRT_STEPS];
        end
    end

    generate
        for (k = 1; k <= POW_STEPS; k++) begin : g_pow
            logic [61:0] prod;
            assign prod = 62'(r_mp[k-1]) * 62'(r_mm[k-1]);

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_mp[k]    <= prod[60:30];
                    r_mm[k]    <= r_mm[k-1];
                    r_mr0[k]   <= r_mr0[k-1];
                    r_mtir[k]  <= r_mtir[k-1];
                    r_mback[k] <= r_mback[k-1];
                end
            end
        end
    endgenerate

    logic [61:0] blend;
    assign blend = 62'(ONE_W - r_mr0[POW_STEPS]) * 62'(r_mp[POW_STEPS]);

    logic [31:0] rsum, rnd;
    logic [16:0] qv;
    assign rsum = 32'(r_t_r0) + 32'(r_t);
    assign rnd  = rsum + 32'd16384;
    assign qv   = rnd[31:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vt        <= r_mp_v[POW_STEPS];
            r_out_valid <= r_vt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t      <= blend[60:30];
            r_t_r0   <= r_mr0[POW_STEPS];
            r_t_tir  <= r_mtir[POW_STEPS];
            r_t_back <= r_mback[POW_STEPS];

            if (r_t_tir) begin
                r_out_data.reflectance    <= REFL_ONE;
                r_out_data.total_internal <= 1'b1;
            end else if (r_t_back) begin
                r_out_data.reflectance    <= REFL_ONE;
                r_out_data.total_internal <= 1'b0;
            end else begin
                r_out_data.reflectance    <= (qv > 17'(REFL_ONE)) ? REFL_ONE : qv[15:0];
                r_out_data.total_internal <= 1'b0;
            end
        end
    end

    a_tir_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.total_internal |-> o_out_data.reflectance == REFL_ONE)
        else $error("total internal result without full reflectance");

    a_refl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.reflectance <= REFL_ONE)
        else $error("reflectance above one");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_sq_v) && $stable(r_dv_v) && $stable(r_mp_v))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// File: tb/schlick_fresnel_reflectance_test.sv
// Testbench for the Schlick reflectance pipeline: directed and random hits checked in order.
`timescale 1ns / 1ps
module schlick_fresnel_reflectance_test;
    import sfr_pkg::*;

    localparam int      N_RANDOM  = 850;
    localparam longint  MAX_CYC   = 400000;
    localparam longint  UNIT      = 64'd1 << 30;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_ready;
    t_hit   i_in_data = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    t_refl  o_out_data;
    logic   o_in_ready_q = 1'b0;

    t_hit   pending_hits[$];
    t_refl  expected_refl[$];
    int     mismatches = 0;
    int     checked = 0;
    int     tir_seen = 0;
    longint cycles = 0;
    bit     hold_feed = 1'b0;
    int     in_gap = 0;
    int     out_gap = 0;

    schlick_fresnel_reflectance uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_refl schlick(input t_hit h);
        t_refl o;
        longint dotp;
        longint unsigned mag, n1, n2, s, sin2, d, sum, r0, m, p, r, q;
        longint cosv;
        dotp = longint'(h.eye_x) * h.normal_x + longint'(h.eye_y) * h.normal_y
             + longint'(h.eye_z) * h.normal_z;
        n1 = (h.index_from < INDEX_ONE) ? 4096 : h.index_from;
        n2 = (h.index_to < INDEX_ONE) ? 4096 : h.index_to;
        mag = (dotp < 0) ? -dotp : dotp;
        mag = mag << 2;
        if (mag > UNIT) mag = UNIT;
        cosv = (dotp < 0) ? -longint'(mag) : longint'(mag);
        o.total_internal = 1'b0;
        o.reflectance = REFL_ONE;
        if (n1 > n2) begin
            s = ((UNIT * UNIT) - mag * mag) >> 30;
            sin2 = (n1 * n1 * s) / (n2 * n2);
            if (sin2 > UNIT) begin
                o.total_internal = 1'b1;
                return o;
            end
            cosv = int_sqrt((UNIT - sin2) << 30);
        end
        if (cosv < 0) return o;
        d = (n1 > n2) ? n1 - n2 : n2 - n1;
        sum = n1 + n2;
        r0 = (d * d * UNIT) / (sum * sum);
        m = UNIT - cosv;
        p = m;
        for (int i = 0; i < 4; i++) p = (p * m) >> 30;
        r = r0 + (((UNIT - r0) * p) >> 30);
        q = (r + (64'd1 << 14)) >> 15;
        if (q > 32768) q = 32768;
        o.reflectance = q[15:0];
        return o;
    endfunction

    function automatic logic [15:0] rand_comp();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'($urandom);
        if (k == 1) return (k[0] ^ $urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic t_hit rand_hit();
        t_hit h;
        real a, b, c, nrm;
        h.eye_x = rand_comp();
        h.eye_y = rand_comp();
        h.eye_z = rand_comp();
        if ($urandom_range(0, 3) != 0) begin
            a = $signed($urandom_range(0, 2000)) - 1000;
            b = $signed($urandom_range(0, 2000)) - 1000;
            c = $signed($urandom_range(0, 2000)) - 1000;
            nrm = $sqrt(a * a + b * b + c * c) + 1.0;
            h.eye_x = $rtoi(16384.0 * a / nrm);
            h.eye_y = $rtoi(16384.0 * b / nrm);
            h.eye_z = $rtoi(16384.0 * c / nrm);
        end
        h.normal_x = rand_comp();
        h.normal_y = rand_comp();
        h.normal_z = rand_comp();
        if ($urandom_range(0, 3) != 0) begin
            h.normal_x = 0;
            h.normal_y = 0;
            h.normal_z = 16384;
        end
        case ($urandom_range(0, 5))
            0: h.index_from = 14'($urandom);
            1: h.index_from = 14'($urandom_range(0, 4095));
            default: h.index_from = 14'($urandom_range(4096, 16383));
        endcase
        h.index_to = ($urandom_range(0, 4) == 0) ? 14'($urandom)
                   : 14'($urandom_range(4096, 12000));
        return h;
    endfunction

    function automatic int gap_len();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_hit mk(input int ex, ey, ez, nx, ny, nz, n1, n2);
        t_hit h;
        h.eye_x = 16'(ex); h.eye_y = 16'(ey); h.eye_z = 16'(ez);
        h.normal_x = 16'(nx); h.normal_y = 16'(ny); h.normal_z = 16'(nz);
        h.index_from = 14'(n1); h.index_to = 14'(n2);
        return h;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !o_in_ready_q)) begin
            if (in_gap > 0 || hold_feed || pending_hits.size() == 0) begin
                i_in_valid <= 1'b0;
                if (in_gap > 0) in_gap <= in_gap - 1;
            end else begin
                i_in_data <= pending_hits.pop_front();
                i_in_valid <= 1'b1;
                in_gap <= gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        o_in_ready_q <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_refl.push_back(schlick(i_in_data));
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_refl.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected result %h", o_out_data);
            end else begin
                t_refl e;
                e = expected_refl.pop_front();
                checked = checked + 1;
                if (e.total_internal) tir_seen = tir_seen + 1;
                if (o_out_data.reflectance !== e.reflectance
                    || o_out_data.total_internal !== e.total_internal) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp refl=%0d tir=%0d got refl=%0d tir=%0d",
                                 checked, e.reflectance, e.total_internal,
                                 o_out_data.reflectance, o_out_data.total_internal);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            i_out_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (i_rst_n && $urandom_range(0, 3) == 0) out_gap <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        pending_hits.push_back(mk(0, 0, 16384, 0, 0, 16384, 4096, 4096));
        pending_hits.push_back(mk(0, 0, 16384, 0, 0, 16384, 6144, 4096));
        pending_hits.push_back(mk(0, 0, 16384, 0, 0, -16384, 4096, 6144));
        pending_hits.push_back(mk(16384, 0, 0, 0, 0, 16384, 4096, 6144));
        pending_hits.push_back(mk(16384, 0, 0, 0, 0, 16384, 6144, 4096));
        pending_hits.push_back(mk(11585, 0, 11585, 0, 0, 16384, 6144, 4096));
        pending_hits.push_back(mk(14189, 0, 8192, 0, 0, 16384, 16383, 4096));
        pending_hits.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 4096, 16383));
        pending_hits.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767, 5000, 4096));
        pending_hits.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, 16383, 16383));
        pending_hits.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
        pending_hits.push_back(mk(0, 0, 0, 0, 0, 0, 16383, 0));
        pending_hits.push_back(mk(0, 16384, 0, 0, 16384, 0, 100, 4095));
        pending_hits.push_back(mk(0, 0, 16384, 0, 0, 16384, 16383, 16383));
        pending_hits.push_back(mk(9459, 9459, 9459, 0, 0, 16384, 6144, 4915));
        pending_hits.push_back(mk(-1, -1, -1, 16384, 0, 0, 6144, 4096));
        pending_hits.push_back(mk(-1, 0, 0, 16384, 0, 0, 4096, 6144));
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        wait (pending_hits.size() == 0);
        @(negedge i_clk);
        hold_feed = 1'b1;
        while (expected_refl.size() != 0 || i_in_valid) @(negedge i_clk);
        hold_feed = 1'b0;
        for (int i = 0; i < N_RANDOM; i++) pending_hits.push_back(rand_hit());
        wait (pending_hits.size() == 0);
        @(negedge i_clk);
        while (i_in_valid || expected_refl.size() != 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("checked %0d hits, %0d with total internal reflection", checked, tir_seen);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
